/* hw/rtl/bat_pkg.sv */
// shared types, constants and the sample rounding function for the block average trend detector
package bat_pkg;

    localparam int SAMPLE_W = 20;
    localparam int VALUE_W  = 16;
    localparam int RUN_W    = 16;

    localparam logic signed [VALUE_W-1:0] VALUE_MAX = 16'sh7FFF;
    localparam logic [RUN_W-1:0]          RUN_MAX   = 16'hFFFF;

    typedef enum logic [1:0] {
        TREND_NOT_DEFINED = 2'd0,
        TREND_FALLING     = 2'd1,
        TREND_RISING      = 2'd2,
        TREND_STABLE      = 2'd3
    } trend_t;

    // rounded sample moving from the input register to the statistics stage
    typedef struct packed {
        logic                      valid;
        logic signed [VALUE_W-1:0] value;
    } stage_t;

    // ceiling of a q4 value, saturated to the signed 16-bit range
    function automatic logic signed [VALUE_W-1:0] round_up_sample(
        input logic signed [SAMPLE_W-1:0] raw
    );
        logic signed [SAMPLE_W:0] biased;
        logic signed [SAMPLE_W:0] shifted;
        biased  = $signed({raw[SAMPLE_W-1], raw}) + 21'sd15;
        shifted = biased >>> 4;
        if (shifted > $signed({{(SAMPLE_W+1-VALUE_W){1'b0}}, VALUE_MAX}))
        begin
            return VALUE_MAX;
        end
        return shifted[VALUE_W-1:0];
    endfunction

endpackage

/* hw/rtl/block_average_trend_detector.sv */
// A sample passes the input register, then the result register. Throughput: one sample per
// cycle unless result_stall holds; rounding sits ahead of the input register, while block sum,
// divide by WINDOW, compare and run count sit in the single stage before the result register.
// Reset (rst_n, asynchronous, active low) empties both registers, clears the sum, position,
// average and run count, sets the trend to not defined and arms priming on the first sample.
// top level of the block average trend detector
module block_average_trend_detector #(
    parameter int WINDOW = 8
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    sample_valid,
    output logic                                    sample_stall,
    input  logic signed [bat_pkg::SAMPLE_W-1:0]     sample_q4,
    output logic                                    result_valid,
    input  logic                                    result_stall,
    output logic signed [bat_pkg::VALUE_W-1:0]      average,
    output logic [1:0]                              trend,
    output logic [bat_pkg::RUN_W-1:0]               run_count,
    output logic                                    average_updated
);
    import bat_pkg::*;

    stage_t stage;
    logic   advance;
    trend_t trend_code;

    // input register with rounding
    bat_input_stage u_input (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_q4    (sample_q4),
        .advance      (advance),
        .stage        (stage)
    );

    // block statistics and result register
    bat_block_stats #(
        .WINDOW (WINDOW)
    ) u_stats (
        .clk             (clk),
        .rst_n           (rst_n),
        .stage           (stage),
        .advance         (advance),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .average         (average),
        .trend           (trend_code),
        .run_count       (run_count),
        .average_updated (average_updated)
    );

    assign trend = trend_code;

endmodule

/* hw/rtl/bat_input_stage.sv */
// input register: takes a sample transfer, rounds it up and holds it for the statistics stage
module bat_input_stage (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    sample_valid,
    output logic                                    sample_stall,
    input  logic signed [bat_pkg::SAMPLE_W-1:0]     sample_q4,
    input  logic                                    advance,
    output bat_pkg::stage_t                         stage
);
    import bat_pkg::*;

    logic                      valid_reg;
    logic signed [VALUE_W-1:0] value_reg;
    logic                      load;

    // the register frees up when empty or when the next stage takes its content
    assign load         = !valid_reg || advance;
    assign sample_stall = !load;

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= sample_valid;
        end
    end

    // rounded sample
    always_ff @(posedge clk)
    begin
        if (load && sample_valid)
        begin
            value_reg <= round_up_sample(sample_q4);
        end
    end

    assign stage.valid = valid_reg;
    assign stage.value = value_reg;

endmodule

/* hw/rtl/bat_div_window.sv */
// truncating division of a block sum by the window length, via an exact reciprocal multiply
module bat_div_window #(
    parameter int WINDOW = 8
) (
    input  logic signed [bat_pkg::VALUE_W+$clog2(WINDOW)-1:0] block_sum,
    output logic signed [bat_pkg::VALUE_W-1:0]                quotient
);
    import bat_pkg::*;

    localparam int DIV_L  = $clog2(WINDOW);
    localparam int SUM_W  = VALUE_W + DIV_L;
    localparam int SHIFT  = SUM_W + DIV_L;
    localparam int PROD_W = 2 * SUM_W + 1;
    // ceil(2^SHIFT / WINDOW) gives the exact floor for every SUM_W-bit magnitude
    localparam longint unsigned RECIP =
        ((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
    localparam logic [SUM_W:0] RECIP_M = (SUM_W+1)'(RECIP);

    logic              negative;
    logic [SUM_W-1:0]  magnitude;
    logic [PROD_W-1:0] product;
    logic [VALUE_W-1:0] mag_quotient;

    // divide the magnitude, then restore the sign for truncation toward zero
    assign negative     = block_sum[SUM_W-1];
    assign magnitude    = negative ? SUM_W'(-block_sum) : SUM_W'(block_sum);
    assign product      = PROD_W'(magnitude) * PROD_W'(RECIP_M);
    assign mag_quotient = product[SHIFT +: VALUE_W];
    assign quotient     = negative ? $signed(-mag_quotient) : $signed(mag_quotient);

endmodule

/* hw/rtl/bat_block_stats.sv */
// block accumulation, average, trend and run count state with the result register
module bat_block_stats #(
    parameter int WINDOW = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  bat_pkg::stage_t                     stage,
    output logic                                advance,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic signed [bat_pkg::VALUE_W-1:0]  average,
    output bat_pkg::trend_t                     trend,
    output logic [bat_pkg::RUN_W-1:0]           run_count,
    output logic                                average_updated
);
    import bat_pkg::*;

    localparam int DIV_L = $clog2(WINDOW);
    localparam int SUM_W = VALUE_W + DIV_L;
    localparam int POS_W = (DIV_L > 0) ? DIV_L : 1;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(WINDOW - 1);

    // block state
    logic signed [SUM_W-1:0]   sum_reg,   sum_next;
    logic [POS_W-1:0]          pos_reg,   pos_next;
    logic signed [VALUE_W-1:0] avg_reg,   avg_next;
    trend_t                    trend_reg, trend_next;
    logic [RUN_W-1:0]          runs_reg,  runs_next;
    logic                      awaiting_reg, awaiting_next;

    // result register
    logic                      res_valid_reg;
    logic signed [VALUE_W-1:0] res_avg_reg;
    trend_t                    res_trend_reg;
    logic [RUN_W-1:0]          res_runs_reg;
    logic                      res_updated_reg;

    logic                      fire;
    logic                      updated;
    logic signed [SUM_W-1:0]   sum_added;
    logic signed [VALUE_W-1:0] block_avg;
    trend_t                    new_trend;

    assign advance = !res_valid_reg || !result_stall;
    assign fire    = stage.valid && advance;

    // sum including the current sample
    assign sum_added = sum_reg + SUM_W'(stage.value);

    bat_div_window #(
        .WINDOW (WINDOW)
    ) u_div (
        .block_sum (sum_added),
        .quotient  (block_avg)
    );

    // direction of the new block average against the previous one
    always_comb
    begin
        if (block_avg < avg_reg)
        begin
            new_trend = TREND_FALLING;
        end
        else if (block_avg > avg_reg)
        begin
            new_trend = TREND_RISING;
        end
        else
        begin
            new_trend = TREND_STABLE;
        end
    end

    // next state for one sample
    always_comb
    begin
        sum_next      = sum_reg;
        pos_next      = pos_reg;
        avg_next      = avg_reg;
        trend_next    = trend_reg;
        runs_next     = runs_reg;
        awaiting_next = awaiting_reg;
        updated       = 1'b0;
        if (awaiting_reg)
        begin
            awaiting_next = 1'b0;
            avg_next      = stage.value;
            trend_next    = TREND_NOT_DEFINED;
            runs_next     = '0;
            sum_next      = '0;
            pos_next      = '0;
            updated       = 1'b1;
        end
        else if (pos_reg == POS_LAST)
        begin
            if (new_trend != trend_reg)
            begin
                runs_next = '0;
            end
            else if (runs_reg != RUN_MAX)
            begin
                runs_next = runs_reg + 1'b1;
            end
            trend_next = new_trend;
            avg_next   = block_avg;
            sum_next   = '0;
            pos_next   = '0;
            updated    = 1'b1;
        end
        else
        begin
            sum_next = sum_added;
            pos_next = pos_reg + 1'b1;
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg      <= '0;
            pos_reg      <= '0;
            avg_reg      <= '0;
            trend_reg    <= TREND_NOT_DEFINED;
            runs_reg     <= '0;
            awaiting_reg <= 1'b1;
        end
        else if (fire)
        begin
            sum_reg      <= sum_next;
            pos_reg      <= pos_next;
            avg_reg      <= avg_next;
            trend_reg    <= trend_next;
            runs_reg     <= runs_next;
            awaiting_reg <= awaiting_next;
        end
    end

    // result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= fire;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_avg_reg     <= avg_next;
            res_trend_reg   <= trend_next;
            res_runs_reg    <= runs_next;
            res_updated_reg <= updated;
        end
    end

    assign result_valid    = res_valid_reg;
    assign average         = res_avg_reg;
    assign trend           = res_trend_reg;
    assign run_count       = res_runs_reg;
    assign average_updated = res_updated_reg;

    // priming leaves an empty block behind
    assert property (@(posedge clk) disable iff (!rst_n)
        awaiting_reg |-> (pos_reg == '0) && (sum_reg == '0))
        else $error("block not empty while awaiting first sample");

    // leaving the priming state always produces a priming result
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(awaiting_reg) |-> res_valid_reg && res_updated_reg)
        else $error("priming sample gave no updated result");

    // an undefined trend never carries a run
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && (res_trend_reg == TREND_NOT_DEFINED) |-> (res_runs_reg == '0))
        else $error("run count nonzero with undefined trend");

    // a transfer into this stage always shows up as a result
    assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> res_valid_reg)
        else $error("accepted sample produced no result");

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// self-checking testbench for the block average trend detector
module testbench;
    import bat_pkg::*;

    localparam int WINDOW          = 8;
    localparam int PHASE_ITEMS     = 568;
    localparam int WATCHDOG_MAX    = 5000;
    localparam int DRAIN_CYCLES    = 10;
    localparam int MAX_REPORTS     = 10;
    localparam int LEVEL_MAX       = 32767;

    typedef struct {
        logic signed [VALUE_W-1:0] average;
        trend_t                    trend;
        logic [RUN_W-1:0]          run_count;
        logic                      updated;
    } block_result_t;

    typedef enum {
        SHAPE_NOISE,
        SHAPE_EXTREME,
        SHAPE_HOLD,
        SHAPE_CLIMB,
        SHAPE_DROP
    } block_shape_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        sample_valid = 1'b0;
    logic                        sample_stall;
    logic signed [SAMPLE_W-1:0]  sample_q4 = '0;
    logic                        result_valid;
    logic                        result_stall = 1'b0;
    logic signed [VALUE_W-1:0]   average;
    logic [1:0]                  trend;
    logic [RUN_W-1:0]            run_count;
    logic                        average_updated;

    // stimulus and expectation stores
    logic signed [SAMPLE_W-1:0]  pending_samples[$];
    block_result_t               expected_results[$];
    int                          sender_idle_pct = 0;
    int                          receiver_stall_pct = 0;

    // shadow copy of the block state
    int                          shadow_sum = 0;
    int                          shadow_position = 0;
    logic signed [VALUE_W-1:0]   shadow_average = '0;
    trend_t                      shadow_trend = TREND_NOT_DEFINED;
    logic [RUN_W-1:0]            shadow_runs = '0;
    bit                          shadow_priming = 1'b1;

    // run statistics
    int                          mismatches = 0;
    int                          results_checked = 0;
    int                          averages_seen = 0;
    int                          longest_run = 0;
    int                          idle_cycles = 0;
    int                          gen_level = 0;

    block_average_trend_detector #(
        .WINDOW          (WINDOW)
    ) DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .sample_valid    (sample_valid),
        .sample_stall    (sample_stall),
        .sample_q4       (sample_q4),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .average         (average),
        .trend           (trend),
        .run_count       (run_count),
        .average_updated (average_updated)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ceiling of a q4 sample, clipped at the top of the 16-bit range
    function automatic logic signed [VALUE_W-1:0] ceil_q4(input logic signed [SAMPLE_W-1:0] raw);
        int whole;
        whole = (int'(raw) + 15) >>> 4;
        if (whole > LEVEL_MAX)
        begin
            whole = LEVEL_MAX;
        end
        return whole[VALUE_W-1:0];
    endfunction

    // advance the shadow state by one sample and return what the block should report
    function automatic block_result_t predict_transfer(input logic signed [SAMPLE_W-1:0] raw);
        logic signed [VALUE_W-1:0] rounded;
        logic signed [VALUE_W-1:0] block_avg;
        trend_t                    direction;
        block_result_t             outcome;
        rounded = ceil_q4(raw);
        outcome.updated = 1'b0;
        if (shadow_priming)
        begin
            // first sample sets the reference average
            shadow_priming  = 1'b0;
            shadow_average  = rounded;
            shadow_trend    = TREND_NOT_DEFINED;
            shadow_runs     = '0;
            shadow_sum      = 0;
            shadow_position = 0;
            outcome.updated = 1'b1;
        end
        else
        begin
            shadow_sum      = shadow_sum + int'(rounded);
            shadow_position = shadow_position + 1;
            if (shadow_position >= WINDOW)
            begin
                // divide truncates toward zero
                block_avg = VALUE_W'(shadow_sum / WINDOW);
                if (block_avg < shadow_average)
                begin
                    direction = TREND_FALLING;
                end
                else if (block_avg > shadow_average)
                begin
                    direction = TREND_RISING;
                end
                else
                begin
                    direction = TREND_STABLE;
                end
                if (direction != shadow_trend)
                begin
                    shadow_runs = '0;
                end
                else if (shadow_runs != RUN_MAX)
                begin
                    shadow_runs = shadow_runs + 1'b1;
                end
                shadow_trend    = direction;
                shadow_average  = block_avg;
                shadow_sum      = 0;
                shadow_position = 0;
                outcome.updated = 1'b1;
            end
        end
        outcome.average   = shadow_average;
        outcome.trend     = shadow_trend;
        outcome.run_count = shadow_runs;
        return outcome;
    endfunction

    function automatic int clamp_level(input int level);
        if (level > LEVEL_MAX)
        begin
            return LEVEL_MAX;
        end
        if (level < -LEVEL_MAX)
        begin
            return -LEVEL_MAX;
        end
        return level;
    endfunction

    // one block whose samples all round up to the given level
    task automatic queue_level_block(input int level);
        for (int i = 0; i < WINDOW; i++)
        begin
            pending_samples.push_back(SAMPLE_W'(level * 16 - int'($urandom_range(0, 15))));
        end
    endtask

    // one block of unrelated samples, either any 20-bit value or edge values
    task automatic queue_scattered_block(input bit edges_only);
        logic signed [SAMPLE_W-1:0] pick;
        for (int i = 0; i < WINDOW; i++)
        begin
            pick = SAMPLE_W'($urandom);
            if (edges_only)
            begin
                case ($urandom_range(0, 5))
                    0: pick = 20'sh80000;
                    1: pick = 20'sh7FFFF;
                    2: pick = '0;
                    3: pick = '1;
                    4: pick = 20'sh00010;
                    default: pick = -20'sd17;
                endcase
            end
            pending_samples.push_back(pick);
        end
    endtask

    // random blocks: mostly level runs that steer the trend, some scattered noise
    task automatic queue_random_phase(input int item_count);
        int           queued;
        int           pick;
        int           repeats;
        block_shape_t shape;
        queued = 0;
        while (queued < item_count)
        begin
            pick  = $urandom_range(0, 9);
            shape = (pick < 2) ? SHAPE_NOISE :
                    (pick == 2) ? SHAPE_EXTREME :
                    (pick < 6) ? SHAPE_HOLD :
                    (pick < 8) ? SHAPE_CLIMB : SHAPE_DROP;
            repeats = $urandom_range(1, 4);
            case (shape)
                SHAPE_NOISE:
                begin
                    queue_scattered_block(1'b0);
                    gen_level = clamp_level($signed(16'($urandom)));
                    repeats   = 1;
                end
                SHAPE_EXTREME:
                begin
                    queue_scattered_block(1'b1);
                    repeats = 1;
                end
                SHAPE_HOLD:
                begin
                    for (int b = 0; b < repeats; b++)
                    begin
                        queue_level_block(gen_level);
                    end
                end
                SHAPE_CLIMB:
                begin
                    for (int b = 0; b < repeats; b++)
                    begin
                        gen_level = clamp_level(gen_level + int'($urandom_range(1, 3000)));
                        queue_level_block(gen_level);
                    end
                end
                default:
                begin
                    for (int b = 0; b < repeats; b++)
                    begin
                        gen_level = clamp_level(gen_level - int'($urandom_range(1, 3000)));
                        queue_level_block(gen_level);
                    end
                end
            endcase
            queued += repeats * WINDOW;
        end
    endtask

    // wait until every queued sample has gone in and every result has come out
    task automatic wait_drained();
        @(negedge clk);
        while (pending_samples.size() != 0 || sample_valid || expected_results.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // sample driver: predicts each accepted transfer, holds payload while stalled
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_valid <= 1'b0;
            sample_q4    <= '0;
        end
        else
        begin
            if (sample_valid && !sample_stall)
            begin
                expected_results.push_back(predict_transfer(sample_q4));
            end
            if (!sample_valid || !sample_stall)
            begin
                if (pending_samples.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct)
                begin
                    sample_valid <= 1'b1;
                    sample_q4    <= pending_samples.pop_front();
                end
                else
                begin
                    sample_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor with random stall and watchdog
    always @(posedge clk or negedge rst_n)
    begin
        block_result_t want;
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            idle_cycles  <= 0;
        end
        else
        begin
            result_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
            if (result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    if (mismatches < MAX_REPORTS)
                    begin
                        $display("unexpected result %0t: avg %0d trend %0d run %0d upd %0b",
                                 $realtime, average, trend, run_count, average_updated);
                    end
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (average !== want.average || trend !== want.trend ||
                        run_count !== want.run_count || average_updated !== want.updated)
                    begin
                        if (mismatches < MAX_REPORTS)
                        begin
                            $display("mismatch at %0t, expected/actual:", $realtime);
                            $display("  avg %0d/%0d trend %0d/%0d run %0d/%0d upd %0b/%0b",
                                     want.average, average, want.trend, trend,
                                     want.run_count, run_count, want.updated, average_updated);
                        end
                        mismatches <= mismatches + 1;
                    end
                    results_checked <= results_checked + 1;
                    if (want.updated)
                    begin
                        averages_seen <= averages_seen + 1;
                    end
                    if (int'(want.run_count) > longest_run)
                    begin
                        longest_run <= int'(want.run_count);
                    end
                end
            end
            // watchdog on cycles with no transfer on either side
            if ((sample_valid && !sample_stall) || (result_valid && !result_stall))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= WATCHDOG_MAX)
            begin
                $display("watchdog: no transfer for %0d cycles", WATCHDOG_MAX);
                $display("testbench NOT OK");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // sequence of phases
    initial
    begin
        sender_idle_pct    = 7;
        receiver_stall_pct = 53;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // priming with the largest input, whose ceiling clips
        pending_samples.push_back(20'sh7FFFF);
        // falling block over edge values, average truncates toward zero
        pending_samples.push_back(20'sh80000);
        pending_samples.push_back(-20'sd1);
        pending_samples.push_back(20'sd0);
        pending_samples.push_back(20'sd1);
        pending_samples.push_back(-20'sd15);
        pending_samples.push_back(20'sd16);
        pending_samples.push_back(20'sd17);
        pending_samples.push_back(-20'sd17);
        // rising back to the top, then a repeat that holds stable
        for (int i = 0; i < 2 * WINDOW; i++)
        begin
            pending_samples.push_back(20'sh7FFFF);
        end
        gen_level = LEVEL_MAX;

        queue_random_phase(PHASE_ITEMS);
        wait_drained();

        sender_idle_pct    = 53;
        receiver_stall_pct = 7;
        queue_random_phase(PHASE_ITEMS);
        wait_drained();

        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        queue_random_phase(PHASE_ITEMS);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("checked %0d results, %0d new averages, longest unchanged run %0d",
                 results_checked, averages_seen, longest_run);
        $display("directed edge samples plus three handshake pressure phases, %0d mismatches",
                 mismatches);
        if (mismatches == 0 && expected_results.size() == 0)
        begin
            $display("testbench OK");
        end
        else
        begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

/* files.f */
hw/rtl/bat_pkg.sv
hw/rtl/bat_input_stage.sv
hw/rtl/bat_div_window.sv
hw/rtl/bat_block_stats.sv
hw/rtl/block_average_trend_detector.sv
bench/testbench.sv
